@@ design/aging_route_table_core_macros.svh @@
// Assertion macros shared by the checker of the route table core.
// No dependencies.
`ifndef AGING_ROUTE_TABLE_CORE_MACROS_SVH
`define AGING_ROUTE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define ART_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("route table check failed");

// next-cycle implication
`define ART_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("route table check failed");

`endif

@@ design/art_pkg.sv @@
// Shared types and constants of the aging route table.
// No dependencies.
package art_pkg;

  localparam logic [1:0] CMD_LEARN  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [3:0] TTL_RESET_VALUE = 4'd3;
  localparam logic [1:0] ADDR_TTL_RELOAD = 2'd0;

  // request token walking down the cell row
  typedef struct packed {
    logic        live;
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [15:0] via;
    logic [3:0]  ttl;
    logic        hit;
    logic [15:0] hop;
    logic        free_seen;
  } art_tok_t;

  // write broadcast issued after a learn scan
  typedef struct packed {
    logic        insert;
    logic        wipe;
    logic [15:0] key;
    logic [15:0] via;
    logic [3:0]  ttl;
  } art_apply_t;

endpackage

@@ design/art_cell.sv @@
// One route table entry with its stage of the request chain.
// Depends on art_pkg.
module art_cell import art_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  art_tok_t   tok_in,
  input  art_apply_t apply,
  output art_tok_t   tok_out
);

  logic [3:0]  ttl;
  logic [15:0] addr;
  logic [15:0] hop;
  logic        cand;
  logic        is_valid;
  logic        is_match;
  logic        own;
  logic        take;
  art_tok_t    tok_next;
  logic [3:0]  ttl_next;
  logic        cand_next;

  assign is_valid = (ttl != 4'd0);
  assign is_match = is_valid && (addr == tok_in.key);
  assign own      = is_match && !tok_in.hit;
  assign take     = apply.wipe ? FIRST : (apply.insert && cand);

  always_comb begin
    tok_next  = tok_in;
    ttl_next  = ttl;
    cand_next = cand;
    if (tok_in.live) begin
      unique case (tok_in.cmd)
        CMD_LEARN: begin
          if (own) ttl_next = tok_in.ttl;
          tok_next.hit       = tok_in.hit | is_match;
          tok_next.free_seen = tok_in.free_seen | !is_valid;
          cand_next          = !is_valid && !tok_in.free_seen;
        end
        CMD_LOOKUP: begin
          if (own) begin
            tok_next.hit = 1'b1;
            tok_next.hop = hop;
          end
        end
        CMD_TICK: begin
          if (is_valid) ttl_next = ttl - 4'd1;
        end
        default: ;
      endcase
    end
    if (apply.wipe && !FIRST) begin
      ttl_next = '0;
    end else if (take) begin
      ttl_next = apply.ttl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl          <= '0;
      cand         <= 1'b0;
      tok_out.live <= 1'b0;
    end else begin
      ttl     <= ttl_next;
      cand    <= cand_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      if (take) begin
        addr <= apply.key;
        hop  <= apply.via;
      end else if (tok_in.live && tok_in.cmd == CMD_LEARN && own) begin
        hop <= tok_in.via;
      end
    end
  end

endmodule

@@ design/art_ctrl.sv @@
// Request sequencer: launches tokens, collects the row's verdict, drives results.
// Depends on art_pkg.
module art_ctrl import art_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] dest_hi,
  input  logic [7:0] dest_lo,
  input  logic [7:0] via_hi,
  input  logic [7:0] via_lo,
  input  logic [3:0] ttl_reload,
  output art_tok_t   head,
  input  art_tok_t   tail,
  output art_apply_t apply,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [7:0] next_hi,
  output logic [7:0] next_lo,
  output logic       table_reset
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  art_tok_t   fin;
  logic       accept;
  logic       emit;
  logic       learn_miss;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign emit       = (state == ST_FIN) && (!out_valid || !out_stall);
  assign learn_miss = (fin.cmd == CMD_LEARN) && !fin.hit;

  always_comb begin
    head.live      = accept;
    head.cmd       = cmd;
    head.key       = {dest_hi, dest_lo};
    head.via       = {via_hi, via_lo};
    head.ttl       = ttl_reload;
    head.hit       = 1'b0;
    head.hop       = '0;
    head.free_seen = 1'b0;
  end

  always_comb begin
    apply.insert = emit && learn_miss && fin.free_seen;
    apply.wipe   = emit && learn_miss && !fin.free_seen;
    apply.key    = fin.key;
    apply.via    = fin.via;
    apply.ttl    = fin.ttl;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (tail.live) state_next = ST_FIN;
      ST_FIN:  if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN && tail.live) fin <= tail;
      if (emit) begin
        out_valid   <= 1'b1;
        found       <= fin.hit && (fin.cmd == CMD_LEARN || fin.cmd == CMD_LOOKUP);
        next_hi     <= (fin.cmd == CMD_LOOKUP && fin.hit) ? fin.hop[15:8] : 8'd0;
        next_lo     <= (fin.cmd == CMD_LOOKUP && fin.hit) ? fin.hop[7:0] : 8'd0;
        table_reset <= learn_miss && !fin.free_seen;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/aging_route_table_core.sv @@
// Aging route table core: top level with the cell row and the config register.
// Depends on art_pkg, art_cell and art_ctrl.
//
// Each request (learn, lookup, tick) is carried by a token that walks the row of
// ENTRIES cells, one cell per cycle, and is collected when it leaves the last cell.
// One request is in flight at a time, so a new request is taken only once the
// previous result has been registered at the output; a finished result waits in
// the output register. A learn that misses writes the first free entry, or wipes
// the table into entry 0, in the cycle its result is registered. The table starts
// empty out of reset with no clearing pass. ttl_reload sits at address 0.
module aging_route_table_core import art_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  dest_hi,
  input  logic [7:0]  dest_lo,
  input  logic [7:0]  via_hi,
  input  logic [7:0]  via_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [7:0]  next_hi,
  output logic [7:0]  next_lo,
  output logic        table_reset,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] ttl_reload;
  art_tok_t   tok [ENTRIES+1];
  art_apply_t apply;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TTL_RELOAD) ? {28'd0, ttl_reload} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_reload <= TTL_RESET_VALUE;
    end else if (psel && penable && pwrite && paddr == ADDR_TTL_RELOAD) begin
      ttl_reload <= pwdata[3:0];
    end
  end

  art_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .dest_hi     (dest_hi),
    .dest_lo     (dest_lo),
    .via_hi      (via_hi),
    .via_lo      (via_lo),
    .ttl_reload  (ttl_reload),
    .head        (tok[0]),
    .tail        (tok[ENTRIES]),
    .apply       (apply),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .next_hi     (next_hi),
    .next_lo     (next_lo),
    .table_reset (table_reset)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    art_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .apply   (apply),
      .tok_out (tok[i+1])
    );
  end

endmodule

@@ design/art_check.sv @@
// Port-level checker for the aging route table core, bound to the top level.
// Depends on aging_route_table_core_macros.svh.
`include "aging_route_table_core_macros.svh"

module art_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [7:0]  next_hi,
  input logic [7:0]  next_lo,
  input logic        table_reset
);

  `ART_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && !in_stall, in_stall)
  `ART_ASSERT_NOW(a_reset_not_hit, clk, rst, out_valid && table_reset, !found)
  `ART_ASSERT_NOW(a_miss_zero_hop, clk, rst, out_valid && !found, next_hi == 8'd0 && next_lo == 8'd0)
  `ART_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

endmodule

bind aging_route_table_core art_check u_check (.*);

@@ sim/aging_route_table_core_test.sv @@
// Testbench for aging_route_table_core: learn, lookup and tick requests, directed then
// random, checked against a route table model kept in the bench, across reload settings.
// Depends on art_pkg and the aging_route_table_core RTL.
module aging_route_table_core_test;
  import art_pkg::*;

  localparam int ROUTE_SLOTS = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 390;
  localparam int PHASES = 5;
  localparam int MODE_SPAN = 650;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = ROUTE_SLOTS + 16;

  typedef struct packed {
    logic       found;
    logic [7:0] next_hi;
    logic [7:0] next_lo;
    logic       table_reset;
  } route_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [15:0] via;
    logic        typed;
    logic        found;
    logic [15:0] hop;
    logic        table_reset;
  } dir_row_t;

  localparam int DIR_COUNT = 23;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_LEARN,  16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b0},
    '{CMD_LEARN,  16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{CMD_LEARN,  16'hFFFF, 16'h1234, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h1234, 1'b0},
    '{CMD_TICK,   16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_LEARN,  16'h00FF, 16'hFF00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'h00FF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_LEARN,  16'hFF00, 16'h00FF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'hFF00, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'h00FF, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_UNUSED, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{CMD_LEARN,  16'hA55A, 16'h5AA5, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{CMD_LOOKUP, 16'hA55A, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_LEARN;
  logic [7:0]  dest_hi = 8'h00;
  logic [7:0]  dest_lo = 8'h00;
  logic [7:0]  via_hi = 8'h00;
  logic [7:0]  via_lo = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [7:0]  next_hi;
  logic [7:0]  next_lo;
  logic        table_reset;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_TTL_RELOAD;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // route table model
  logic [3:0]  ttl_tab [ROUTE_SLOTS];
  logic [15:0] addr_tab [ROUTE_SLOTS];
  logic [15:0] hop_tab [ROUTE_SLOTS];
  logic [3:0]  model_reload;

  route_res_t route_expect [$];
  int mismatches = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_done = 0;
  int hold_left = 0;

  aging_route_table_core #(.ENTRIES(ROUTE_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .dest_hi(dest_hi), .dest_lo(dest_lo), .via_hi(via_hi), .via_lo(via_lo),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .next_hi(next_hi), .next_lo(next_lo), .table_reset(table_reset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic route_res_t route_step(logic [1:0] op, logic [15:0] addr,
                                            logic [15:0] via);
    route_res_t res;
    int hit;
    int slot;
    res = '0;
    hit = -1;
    slot = -1;
    for (int i = 0; i < ROUTE_SLOTS; i++) begin
      if (hit < 0 && ttl_tab[i] != 4'd0 && addr_tab[i] == addr) hit = i;
      if (slot < 0 && ttl_tab[i] == 4'd0) slot = i;
    end
    case (op)
      CMD_LEARN: begin
        if (hit >= 0) begin
          ttl_tab[hit] = model_reload;
          hop_tab[hit] = via;
          res.found = 1'b1;
        end else begin
          if (slot < 0) begin
            for (int i = 1; i < ROUTE_SLOTS; i++) ttl_tab[i] = 4'd0;
            slot = 0;
            res.table_reset = 1'b1;
          end
          ttl_tab[slot] = model_reload;
          addr_tab[slot] = addr;
          hop_tab[slot] = via;
        end
      end
      CMD_LOOKUP: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          {res.next_hi, res.next_lo} = hop_tab[hit];
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < ROUTE_SLOTS; i++)
          if (ttl_tab[i] != 4'd0) ttl_tab[i] = ttl_tab[i] - 4'd1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly a small pool so learns and lookups meet; the rest fully random
  function automatic logic [15:0] pick_addr();
    int idx;
    idx = $urandom_range(0, 47);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return {8'(idx % 6), 8'(idx * 29)};
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic send_route(input logic [1:0] op, input logic [15:0] addr,
                            input logic [15:0] via, input logic typed,
                            input route_res_t typed_res);
    route_res_t res;
    if (items_sent < MODE_SPAN) begin
      send_idle_pct = 21;
      recv_idle_pct = 45;
    end else if (items_sent < 2 * MODE_SPAN) begin
      send_idle_pct = 45;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    {dest_hi, dest_lo} = addr;
    {via_hi, via_lo} = via;
    do @(posedge clk); while (in_stall);
    res = route_step(op, addr, via);
    route_expect.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reload(input logic [3:0] value);
    logic [31:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_TTL_RELOAD;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    model_reload = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd[3:0] !== value)
      flag_error($sformatf("ttl_reload readback: expected %0d, got %0d", value, rd[3:0]));
  endtask

  // receiver: random stall, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_done != hold_seq) begin
      hold_done = hold_seq;
      hold_left = HOLD_CYCLES;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    route_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (route_expect.size() == 0) begin
        flag_error($sformatf("unexpected result: found=%0d next=%02h%02h table_reset=%0d",
                             found, next_hi, next_lo, table_reset));
      end else begin
        want = route_expect.pop_front();
        if (found !== want.found || next_hi !== want.next_hi ||
            next_lo !== want.next_lo || table_reset !== want.table_reset)
          flag_error($sformatf({"result mismatch: expected found=%0d next=%02h%02h ",
                                "table_reset=%0d, got found=%0d next=%02h%02h table_reset=%0d"},
                               want.found, want.next_hi, want.next_lo, want.table_reset,
                               found, next_hi, next_lo, table_reset));
      end
    end
  end

  initial begin
    int n;
    int ph;
    int k;
    int j;
    int r;
    logic [15:0] base;
    logic [3:0] reload_set [PHASES];
    model_reload = TTL_RESET_VALUE;
    for (n = 0; n < ROUTE_SLOTS; n++) begin
      ttl_tab[n] = 4'd0;
      addr_tab[n] = 16'h0;
      hop_tab[n] = 16'h0;
    end
    repeat (5) @(negedge clk);
    rst = 1'b0;

    for (n = 0; n < DIR_COUNT; n++)
      send_route(DIR_ROWS[n].op, DIR_ROWS[n].addr, DIR_ROWS[n].via, DIR_ROWS[n].typed,
                 route_res_t'({DIR_ROWS[n].found, DIR_ROWS[n].hop, DIR_ROWS[n].table_reset}));

    reload_set = '{4'd15, 4'd1, 4'd0, 4'($urandom_range(2, 14)), TTL_RESET_VALUE};
    for (ph = 0; ph < PHASES; ph++) begin
      in_valid = 1'b0;
      while (route_expect.size() != 0) @(negedge clk);
      write_reload(reload_set[ph]);
      if (ph == 1 || ph == 3) hold_seq++;
      k = 0;
      while (k < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          // burst of distinct learns that overflows the table
          base = 16'($urandom);
          for (j = 0; j < ROUTE_SLOTS + 2; j++)
            send_route(CMD_LEARN, base + 16'(j), 16'($urandom), 1'b0, '0);
          k += ROUTE_SLOTS + 2;
        end else begin
          if (r < 52) send_route(CMD_LEARN, pick_addr(), 16'($urandom), 1'b0, '0);
          else if (r < 86) send_route(CMD_LOOKUP, pick_addr(), 16'($urandom), 1'b0, '0);
          else if (r < 97) send_route(CMD_TICK, pick_addr(), 16'($urandom), 1'b0, '0);
          else send_route(CMD_UNUSED, pick_addr(), 16'($urandom), 1'b0, '0);
          k++;
        end
      end
    end

    in_valid = 1'b0;
    while (route_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
